// File: rtl/b85_pkg.sv
package b85_pkg;

  localparam logic [6:0]  RADIX       = 7'd85;
  localparam logic [6:0]  CHAR_OFFSET = 7'd33;
  localparam logic [6:0]  CHAR_MAX    = CHAR_OFFSET + RADIX - 7'd1;
  localparam int          GROUP_BYTES = 4;
  localparam int          QUEUE_DEPTH = 2;

  // floor(x / 85) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP       = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_line;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       group_done;
    logic       line_done;
  } out_item_t;

  // one closed group: padded word, byte count minus one, end of line
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  n_m1;
    logic        last;
  } grp_t;

endpackage

// File: rtl/b85_front.sv
module b85_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  b85_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output b85_pkg::grp_t     q_item
);

  logic [23:0] group_r, group_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        accept;
  logic        closes;
  logic [31:0] word;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign closes   = in_item.last_of_line || (count_r == 2'd3);
  assign q_push   = accept && closes;

  always_comb begin
    case (count_r)
      2'd0:    word = {in_item.data_byte, 24'd0};
      2'd1:    word = {group_r[7:0], in_item.data_byte, 16'd0};
      2'd2:    word = {group_r[15:0], in_item.data_byte, 8'd0};
      2'd3:    word = {group_r, in_item.data_byte};
      default: word = '0;
    endcase
  end

  assign q_item.word = word;
  assign q_item.n_m1 = count_r;
  assign q_item.last = in_item.last_of_line;

  always_comb begin
    group_nxt = group_r;
    count_nxt = count_r;
    if (accept) begin
      if (closes) begin
        group_nxt = '0;
        count_nxt = '0;
      end else begin
        group_nxt = {group_r[15:0], in_item.data_byte};
        count_nxt = count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      count_r <= '0;
    end else begin
      group_r <= group_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/b85_queue.sv
module b85_queue #(
  parameter int DEPTH = b85_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b85_pkg::grp_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output b85_pkg::grp_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b85_pkg::grp_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/b85_back.sv
module b85_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  b85_pkg::grp_t      q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output b85_pkg::out_item_t out_item
);

  localparam logic [2:0] NUM_DIV = 3'(b85_pkg::GROUP_BYTES);

  // divide unit
  logic              conv_valid_r, conv_valid_nxt;
  logic [2:0]        conv_step_r;
  logic [31:0]       conv_quot_r;
  logic [6:0]        conv_dig_r [1:4];
  logic [1:0]        conv_n_m1_r;
  logic              conv_last_r;
  logic [63:0]       prod;
  logic [31:0]       q32;
  logic [31:0]       rem32;
  logic              conv_stepping;
  logic              conv_xfer;

  // character issue
  logic              emit_valid_r, emit_valid_nxt;
  logic [2:0]        emit_idx_r, emit_idx_nxt;
  logic [6:0]        emit_dig_r [0:4];
  logic [1:0]        emit_n_m1_r;
  logic              emit_last_r;
  logic              emit_end;
  logic              emit_free;
  logic              issue;

  // output register
  logic               out_valid_r, out_valid_nxt;
  b85_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_slot;

  assign prod  = 64'(conv_quot_r) * 64'(b85_pkg::RECIP);
  assign q32   = 32'(prod[63:b85_pkg::RECIP_SHIFT]);
  assign rem32 = conv_quot_r - q32 * 32'(b85_pkg::RADIX);

  assign conv_stepping = conv_valid_r && (conv_step_r != NUM_DIV);

  assign out_slot  = !out_valid_r || !out_stall;
  assign issue     = emit_valid_r && out_slot;
  assign emit_end  = (emit_idx_r == (3'(emit_n_m1_r) + 3'd1));
  assign emit_free = !emit_valid_r || (issue && emit_end);

  assign conv_xfer = conv_valid_r && (conv_step_r == NUM_DIV) && emit_free;
  assign q_pop     = q_valid && (!conv_valid_r || conv_xfer);

  always_comb begin
    conv_valid_nxt = conv_valid_r;
    if (q_pop) begin
      conv_valid_nxt = 1'b1;
    end else if (conv_xfer) begin
      conv_valid_nxt = 1'b0;
    end
  end

  // Least significant digit leaves first; shift it up so each digit lands in place.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      conv_quot_r <= q_item.word;
      conv_n_m1_r <= q_item.n_m1;
      conv_last_r <= q_item.last;
      conv_step_r <= '0;
    end else if (conv_stepping) begin
      conv_quot_r   <= q32;
      conv_dig_r[1] <= rem32[6:0];
      conv_dig_r[2] <= conv_dig_r[1];
      conv_dig_r[3] <= conv_dig_r[2];
      conv_dig_r[4] <= conv_dig_r[3];
      conv_step_r   <= conv_step_r + 3'd1;
    end
  end

  always_comb begin
    emit_valid_nxt = emit_valid_r;
    emit_idx_nxt   = emit_idx_r;
    if (conv_xfer) begin
      emit_valid_nxt = 1'b1;
      emit_idx_nxt   = '0;
    end else if (issue) begin
      if (emit_end) begin
        emit_valid_nxt = 1'b0;
      end
      emit_idx_nxt = emit_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_xfer) begin
      emit_dig_r[0] <= conv_quot_r[6:0];
      emit_dig_r[1] <= conv_dig_r[1];
      emit_dig_r[2] <= conv_dig_r[2];
      emit_dig_r[3] <= conv_dig_r[3];
      emit_dig_r[4] <= conv_dig_r[4];
      emit_n_m1_r   <= conv_n_m1_r;
      emit_last_r   <= conv_last_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (issue) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.char_code  = emit_dig_r[emit_idx_r] + b85_pkg::CHAR_OFFSET;
      out_item_nxt.group_done = emit_end;
      out_item_nxt.line_done  = emit_end && emit_last_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_valid_r <= 1'b0;
      emit_valid_r <= 1'b0;
      emit_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      conv_valid_r <= conv_valid_nxt;
      emit_valid_r <= emit_valid_nxt;
      emit_idx_r   <= emit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/base85_text_encoder.sv
// Base-85 line encoder. Bytes are taken one per transaction, at up to one per
// cycle while the group queue has room; every fourth byte, or the byte flagged
// last of line, closes a group that is queued for the back end. The back end
// splits each group into digits (four divide-by-85 steps of a shared
// reciprocal multiplier, then a hand-over) while the previous group's
// characters go out, one per cycle while out_stall is low, through a
// registered output. A closed group of n bytes yields n+1 characters, so a
// full group of 4 bytes yields 5. A short group still needs all four divide
// steps. The last character of a group carries group_done, that of the line
// also line_done; the consumer supplies the newline.
module base85_text_encoder #(
  parameter int QUEUE_DEPTH = b85_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  b85_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output b85_pkg::out_item_t out_item
);

  logic          q_full;
  logic          q_push;
  b85_pkg::grp_t q_push_item;
  logic          q_pop;
  logic          q_valid;
  b85_pkg::grp_t q_pop_item;

  b85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  b85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  b85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/b85_checker.sv
module b85_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input b85_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input b85_pkg::out_item_t out_item
);

  // output register empties on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // hold a stalled transaction unchanged
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_line_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.line_done |-> out_item.group_done)
    else $error("line_done without group_done");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.char_code >= b85_pkg::CHAR_OFFSET) &&
                  (out_item.char_code <= b85_pkg::CHAR_MAX))
    else $error("character outside base-85 alphabet");

  // a stalled input transaction stays offered and unchanged
  a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed or withdrawn");

endmodule

bind base85_text_encoder b85_checker u_b85_checker (.*);

// File: verif/tb_top.sv
module tb_top;

  localparam int unsigned B85_RADIX  = 85;
  localparam int unsigned ASCII_BIAS = 33;
  localparam int          DIR_N      = 24;
  localparam int          PHASE_ITEMS = 150;

  typedef struct {
    logic [7:0]  data;
    bit          last;
    bit          typed;
    int          n;
    logic [39:0] text;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  b85_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  b85_pkg::out_item_t out_item;

  // predictor state: open group and how many bytes it holds
  logic [23:0] grp_acc = '0;
  logic [1:0]  grp_cnt = '0;

  b85_pkg::out_item_t pending_chars[$];
  int                 bad_chars = 0;
  int                 in_idle_pct = 29;
  int                 out_idle_pct = 56;

  // typed rows: text holds the expected characters, flags follow the group's end
  dir_row_t dir_rows [DIR_N] = '{
    '{8'h00, 1'b1, 1'b1, 2, "!!"},
    '{8'hFF, 1'b1, 1'b1, 2, "rr"},
    '{8'hFF, 1'b0, 1'b1, 0, 40'h0},
    '{8'hFF, 1'b0, 1'b1, 0, 40'h0},
    '{8'hFF, 1'b0, 1'b1, 0, 40'h0},
    '{8'hFF, 1'b0, 1'b1, 5, "s8W-!"},
    '{8'h00, 1'b0, 1'b1, 0, 40'h0},
    '{8'h00, 1'b0, 1'b1, 0, 40'h0},
    '{8'h00, 1'b0, 1'b1, 0, 40'h0},
    '{8'h00, 1'b1, 1'b1, 5, "!!!!!"},
    '{8'h4D, 1'b0, 1'b0, 0, 40'h0},
    '{8'h61, 1'b1, 1'b0, 0, 40'h0},
    '{8'h80, 1'b0, 1'b0, 0, 40'h0},
    '{8'h01, 1'b0, 1'b0, 0, 40'h0},
    '{8'h7F, 1'b1, 1'b0, 0, 40'h0},
    '{8'hAA, 1'b0, 1'b0, 0, 40'h0},
    '{8'h55, 1'b0, 1'b0, 0, 40'h0},
    '{8'hAA, 1'b0, 1'b0, 0, 40'h0},
    '{8'h55, 1'b0, 1'b0, 0, 40'h0},
    '{8'h01, 1'b1, 1'b0, 0, 40'h0},
    '{8'hFE, 1'b0, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 1'b0, 0, 40'h0},
    '{8'hEF, 1'b0, 1'b0, 0, 40'h0},
    '{8'h01, 1'b1, 1'b0, 0, 40'h0}
  };

  base85_text_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predictor by one byte; queue the characters it closes if keep is set.
  task automatic encode_byte(input b85_pkg::in_item_t it, input bit keep);
    logic [31:0]        word;
    logic [6:0]         digit [5];
    int                 nb;
    b85_pkg::out_item_t c;
    if (grp_cnt < 2'd3 && !it.last_of_line) begin
      grp_acc = {grp_acc[15:0], it.data_byte};
      grp_cnt = grp_cnt + 2'd1;
    end else begin
      nb = int'(grp_cnt) + 1;
      // pad a short group with zero bytes on the right
      word = {grp_acc, it.data_byte} << (8 * (4 - nb));
      for (int i = 4; i >= 0; i--) begin
        digit[i] = 7'(word % B85_RADIX);
        word = word / B85_RADIX;
      end
      for (int i = 0; i <= nb; i++) begin
        c.char_code  = digit[i] + 7'(ASCII_BIAS);
        c.group_done = (i == nb);
        c.line_done  = (i == nb) && it.last_of_line;
        if (keep) pending_chars.push_back(c);
      end
      grp_acc = '0;
      grp_cnt = '0;
    end
  endtask

  task automatic send_byte(input b85_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : char_check
    b85_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char code %0d gd %b ld %b", $time,
                 out_item.char_code, out_item.group_done, out_item.line_done);
        bad_chars++;
      end else begin
        want = pending_chars.pop_front();
        if (out_item.char_code !== want.char_code ||
            out_item.group_done !== want.group_done ||
            out_item.line_done !== want.line_done) begin
          $display("%0t: expected code %0d gd %b ld %b, got code %0d gd %b ld %b",
                   $time, want.char_code, want.group_done, want.line_done,
                   out_item.char_code, out_item.group_done, out_item.line_done);
          bad_chars++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    b85_pkg::in_item_t cur;
    int                sent;
    int                line_len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      cur.data_byte    = dir_rows[r].data;
      cur.last_of_line = dir_rows[r].last;
      send_byte(cur);
      encode_byte(cur, !dir_rows[r].typed);
      if (dir_rows[r].typed) begin
        for (int k = 0; k < dir_rows[r].n; k++) begin
          pending_chars.push_back('{
            char_code:  dir_rows[r].text[8 * (dir_rows[r].n - 1 - k) +: 7],
            group_done: (k == dir_rows[r].n - 1),
            line_done:  (k == dir_rows[r].n - 1) && dir_rows[r].last});
        end
      end
    end
    // hold the sender until every character of the directed lines is out
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 29 : (ph == 1) ? 56 : 0;
      out_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 29 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly ordinary lines, with a share of short ones to hit partial groups
        line_len = $urandom_range(1, ($urandom_range(3) == 0) ? 3 : 12);
        for (int j = 0; j < line_len; j++) begin
          if ($urandom_range(7) == 0)
            cur.data_byte = $urandom_range(1) ? 8'hFF : 8'h00;
          else
            cur.data_byte = 8'($urandom_range(255));
          cur.last_of_line = (j == line_len - 1);
          send_byte(cur);
          encode_byte(cur, 1'b1);
          sent++;
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (bad_chars == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/b85_pkg.sv
rtl/b85_front.sv
rtl/b85_queue.sv
rtl/b85_back.sv
rtl/base85_text_encoder.sv
rtl/b85_checker.sv
verif/tb_top.sv
